// ----- hdl/evbp_pkg.sv -----
package evbp_pkg;

	localparam int VAL_W = 32;
	localparam int WID_W = 6;
	localparam int BYTE_W = 8;
	localparam int SLOT_W = 16;
	localparam int BUF_W = 17;
	localparam int SLOT_INDEX_BITS_DEF = 16;
	localparam logic [BUF_W-1:0] BUF_RESET = 17'h10000;
	localparam logic [WID_W-1:0] MAX_WIDTH = 6'd32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SHIFT,
		ST_FIN
	} fsm_state_t;

	typedef struct packed {
		logic vld;
		logic fin;
		logic data;
	} bit_item_t;

	function automatic logic [WID_W-1:0] clamp_width(input logic [WID_W-1:0] w);
		return (w > MAX_WIDTH) ? MAX_WIDTH : w;
	endfunction

	function automatic logic [VAL_W-1:0] field_max(input logic [WID_W-1:0] w);
		logic [VAL_W:0] m;
		m = ({{VAL_W{1'b0}}, 1'b1} << w) - {{VAL_W{1'b0}}, 1'b1};
		return m[VAL_W-1:0];
	endfunction

endpackage

// ----- hdl/evbp_ifs.sv -----
interface evbp_item_if;
	logic valid;
	logic ready;
	logic action;
	logic [evbp_pkg::VAL_W-1:0] value;
	logic [evbp_pkg::WID_W-1:0] width_first;
	logic [evbp_pkg::WID_W-1:0] width_second;
	logic [evbp_pkg::WID_W-1:0] width_third;

	modport source (output valid, action, value, width_first, width_second, width_third,
		input ready);
	modport sink (input valid, action, value, width_first, width_second, width_third,
		output ready);
endinterface

interface evbp_res_if;
	logic valid;
	logic ready;
	logic [evbp_pkg::BYTE_W-1:0] out_byte;
	logic [evbp_pkg::SLOT_W-1:0] byte_slot;
	logic [evbp_pkg::VAL_W-1:0] total_bits;
	logic last;

	modport source (output valid, out_byte, byte_slot, total_bits, last, input ready);
	modport sink (input valid, out_byte, byte_slot, total_bits, last, output ready);
endinterface

interface evbp_cfg_if;
	logic valid;
	logic ready;
	logic [evbp_pkg::BUF_W-1:0] buffer_bytes;

	modport source (output valid, buffer_bytes, input ready);
	modport sink (input valid, buffer_bytes, output ready);
endinterface

// ----- hdl/evbp_field_ctl.sv -----
module evbp_field_ctl (
	input  logic                  clk,
	input  logic                  arst_n,
	evbp_item_if.sink             item_in,
	output evbp_pkg::bit_item_t   bits,
	input  logic                  bit_ready
);

	evbp_pkg::fsm_state_t state_q, state_nxt;

	logic                          act_q;
	logic [evbp_pkg::VAL_W-1:0]    val_q;
	logic [evbp_pkg::WID_W-1:0]    w0_q, w1_q, w2_q;
	logic [1:0]                    k_q;
	logic [evbp_pkg::VAL_W-1:0]    sh_q;
	logic [evbp_pkg::WID_W-1:0]    cnt_q;
	logic                          more_q;

	logic [evbp_pkg::WID_W-1:0]    wk;
	logic [evbp_pkg::VAL_W-1:0]    mx;
	logic [evbp_pkg::VAL_W-1:0]    esc;
	logic [evbp_pkg::VAL_W-1:0]    fval;
	logic                          more;
	logic                          in_acc;
	logic                          bit_acc;
	logic                          last_bit;

	always_comb begin
		case (k_q)
			2'd0: wk = w0_q;
			2'd1: wk = w1_q;
			default: wk = w2_q;
		endcase
	end

	assign mx       = evbp_pkg::field_max(wk);
	assign esc      = (val_q < mx) ? val_q : mx;
	assign fval     = act_q ? esc : (val_q & mx);
	assign more     = act_q && (val_q >= mx) && (k_q != 2'd2);
	assign in_acc   = item_in.valid && item_in.ready;
	assign bit_acc  = (state_q == evbp_pkg::ST_SHIFT) && bit_ready;
	assign last_bit = (cnt_q == evbp_pkg::WID_W'(1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			evbp_pkg::ST_IDLE: begin
				if (in_acc) state_nxt = evbp_pkg::ST_LOAD;
			end
			evbp_pkg::ST_LOAD: begin
				if (wk != '0) state_nxt = evbp_pkg::ST_SHIFT;
				else if (more) state_nxt = evbp_pkg::ST_LOAD;
				else state_nxt = evbp_pkg::ST_FIN;
			end
			evbp_pkg::ST_SHIFT: begin
				if (bit_acc && last_bit) begin
					state_nxt = more_q ? evbp_pkg::ST_LOAD : evbp_pkg::ST_FIN;
				end
			end
			evbp_pkg::ST_FIN: begin
				if (bit_ready) state_nxt = evbp_pkg::ST_IDLE;
			end
			default: state_nxt = evbp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_in.ready = 1'b0;
		bits.vld      = 1'b0;
		bits.fin      = 1'b0;
		bits.data     = sh_q[evbp_pkg::VAL_W-1];
		case (state_q)
			evbp_pkg::ST_IDLE: item_in.ready = 1'b1;
			evbp_pkg::ST_SHIFT: bits.vld = 1'b1;
			evbp_pkg::ST_FIN: begin
				bits.vld = 1'b1;
				bits.fin = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= evbp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q <= item_in.action;
			val_q <= item_in.value;
			w0_q  <= evbp_pkg::clamp_width(item_in.width_first);
			w1_q  <= evbp_pkg::clamp_width(item_in.width_second);
			w2_q  <= evbp_pkg::clamp_width(item_in.width_third);
			k_q   <= 2'd0;
		end else if (state_q == evbp_pkg::ST_LOAD) begin
			sh_q   <= fval << (evbp_pkg::MAX_WIDTH - wk);
			cnt_q  <= wk;
			more_q <= more;
			val_q  <= val_q - esc;
			k_q    <= k_q + 2'd1;
		end else if (bit_acc) begin
			sh_q  <= {sh_q[evbp_pkg::VAL_W-2:0], 1'b0};
			cnt_q <= cnt_q - evbp_pkg::WID_W'(1);
		end
	end

	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == evbp_pkg::ST_LOAD)
		else $error("accepted item did not start field load");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == evbp_pkg::ST_IDLE |-> !bits.vld)
		else $error("bit offered while idle");
	a_shift_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == evbp_pkg::ST_SHIFT |-> cnt_q != '0)
		else $error("shifting with empty bit count");

endmodule

// ----- hdl/evbp_byte_asm.sv -----
module evbp_byte_asm #(
	parameter int SLOT_INDEX_BITS = evbp_pkg::SLOT_INDEX_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [evbp_pkg::BUF_W-1:0]  buf_bytes,
	input  evbp_pkg::bit_item_t         bits,
	output logic                        bit_ready,
	evbp_res_if.source                  res_out
);

	localparam int SB = SLOT_INDEX_BITS;
	localparam int NW = (SB + 1 > evbp_pkg::BUF_W) ? SB + 1 : evbp_pkg::BUF_W;

	logic [evbp_pkg::BYTE_W-1:0] partial_q;
	logic [2:0]                  pos_q;
	logic [SB-1:0]               slot_q;
	logic [evbp_pkg::VAL_W-1:0]  total_q;

	logic                        held_vld_q;
	logic [evbp_pkg::BYTE_W-1:0] held_byte_q;
	logic [SB-1:0]               held_slot_q;
	logic [evbp_pkg::VAL_W-1:0]  held_total_q;

	logic                        out_vld_q;
	logic [evbp_pkg::BYTE_W-1:0] out_byte_q;
	logic [evbp_pkg::SLOT_W-1:0] out_slot_q;
	logic [evbp_pkg::VAL_W-1:0]  out_total_q;
	logic                        out_last_q;

	logic                        out_free;
	logic                        bit_acc;
	logic                        fin_acc;
	logic                        byte_done;
	logic                        push;
	logic [evbp_pkg::BYTE_W-1:0] new_byte;
	logic [SB:0]                 slot_inc;
	logic                        wrap;
	logic [evbp_pkg::VAL_W-1:0]  total_inc;

	assign out_free  = !out_vld_q || res_out.ready;
	assign bit_ready = out_free || !held_vld_q || (!bits.fin && pos_q != 3'd0);
	assign bit_acc   = bits.vld && !bits.fin && bit_ready;
	assign fin_acc   = bits.vld && bits.fin && bit_ready;
	assign byte_done = bit_acc && (pos_q == 3'd0);
	assign push      = held_vld_q && (byte_done || fin_acc);
	assign total_inc = total_q + evbp_pkg::VAL_W'(1);
	assign slot_inc  = {1'b0, slot_q} + (SB+1)'(1);
	assign wrap      = slot_inc[SB] || (NW'(slot_inc) >= NW'(buf_bytes));

	always_comb begin
		new_byte        = partial_q;
		new_byte[pos_q] = partial_q[pos_q] | bits.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q  <= '0;
			pos_q      <= 3'd7;
			slot_q     <= '0;
			total_q    <= '0;
			held_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (bit_acc) begin
				total_q <= total_inc;
				if (pos_q == 3'd0) begin
					partial_q <= '0;
					pos_q     <= 3'd7;
					slot_q    <= wrap ? '0 : slot_inc[SB-1:0];
				end else begin
					partial_q <= new_byte;
					pos_q     <= pos_q - 3'd1;
				end
			end
			if (byte_done) held_vld_q <= 1'b1;
			else if (fin_acc) held_vld_q <= 1'b0;
			if (push) out_vld_q <= 1'b1;
			else if (res_out.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_done) begin
			held_byte_q  <= new_byte;
			held_slot_q  <= slot_q;
			held_total_q <= total_inc;
		end
		if (push) begin
			out_byte_q  <= held_byte_q;
			out_slot_q  <= evbp_pkg::SLOT_W'(held_slot_q);
			out_total_q <= held_total_q;
			out_last_q  <= fin_acc;
		end
	end

	assign res_out.valid      = out_vld_q;
	assign res_out.out_byte   = out_byte_q;
	assign res_out.byte_slot  = out_slot_q;
	assign res_out.total_bits = out_total_q;
	assign res_out.last       = out_last_q;

	a_byte_held: assert property (@(posedge clk) disable iff (!arst_n)
		byte_done |=> held_vld_q)
		else $error("completed byte not held");
	a_fin_flush: assert property (@(posedge clk) disable iff (!arst_n)
		fin_acc |=> !held_vld_q)
		else $error("held byte survived item end");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("byte pushed into occupied output register");
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		bit_acc |=> total_q == $past(total_q) + evbp_pkg::VAL_W'(1))
		else $error("bit total did not advance");

endmodule

// ----- hdl/escaped_value_bit_packer_core.sv -----
// Escaped-value bit packer.
// item_in: one item per valid/ready handshake. action 0 appends the low width_first
// bits of value; action 1 writes value escape coded over up to three fields
// (width_first, width_second, width_third). Widths above 32 act as 32.
// res_out: one item per completed byte, earliest bit in bit 7, with its ring slot,
// the running bit total through that byte, and last set on the item's final byte.
// cfg: writes buffer_bytes, the ring length; write it only while the block is idle.
// Timing: bits are shifted one per cycle while bit_ready is high. An item occupies
// the input side through an accept, a load per field, a shift per bit and an end
// marker. item_in.ready is high only between items. A completed byte is held until
// the next byte or the item end decides its last flag, then moves to the output
// register, so a byte appears in the cycle after that point.
// A stalled receiver stops the bit shifter only when a second byte or the end
// marker needs the occupied output register.
// Reset clears the partial byte, bit position (next bit is bit 7), slot index,
// bit total and all valid flags; buffer_bytes returns to 65536.
module escaped_value_bit_packer_core #(
	parameter int SLOT_INDEX_BITS = evbp_pkg::SLOT_INDEX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	evbp_item_if.sink   item_in,
	evbp_res_if.source  res_out,
	evbp_cfg_if.sink    cfg
);

	logic [evbp_pkg::BUF_W-1:0] buf_bytes_q;
	evbp_pkg::bit_item_t        bits;
	logic                       bit_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_bytes_q <= evbp_pkg::BUF_RESET;
		end else if (cfg.valid && cfg.ready) begin
			buf_bytes_q <= cfg.buffer_bytes;
		end
	end

	evbp_field_ctl u_field_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_in),
		.bits      (bits),
		.bit_ready (bit_ready)
	);

	evbp_byte_asm #(
		.SLOT_INDEX_BITS (SLOT_INDEX_BITS)
	) u_byte_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.buf_bytes (buf_bytes_q),
		.bits      (bits),
		.bit_ready (bit_ready),
		.res_out   (res_out)
	);

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int SLOT_BITS = evbp_pkg::SLOT_INDEX_BITS_DEF;
	localparam bit ACT_PLAIN = 1'b0;
	localparam bit ACT_ESCAPE = 1'b1;
	localparam int SETTLE_CYCLES = 150;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS = 19;
	localparam int NUM_PHASES = 7;
	localparam int NUM_ROWS = 19;

	typedef struct packed {
		bit action;
		bit [evbp_pkg::VAL_W-1:0] value;
		bit [evbp_pkg::WID_W-1:0] w1;
		bit [evbp_pkg::WID_W-1:0] w2;
		bit [evbp_pkg::WID_W-1:0] w3;
	} pack_req_t;

	typedef struct packed {
		bit [evbp_pkg::BYTE_W-1:0] data;
		bit [evbp_pkg::SLOT_W-1:0] slot;
		bit [evbp_pkg::VAL_W-1:0] total;
		bit last;
	} packed_byte_t;

	typedef struct packed {
		bit action;
		bit [evbp_pkg::VAL_W-1:0] value;
		bit [evbp_pkg::WID_W-1:0] w1;
		bit [evbp_pkg::WID_W-1:0] w2;
		bit [evbp_pkg::WID_W-1:0] w3;
		bit typed;
		bit [evbp_pkg::BYTE_W-1:0] want_byte;
		bit [evbp_pkg::SLOT_W-1:0] want_slot;
		bit [evbp_pkg::VAL_W-1:0] want_total;
	} stim_row_t;

	stim_row_t directed_rows [NUM_ROWS] = '{
		'{ACT_PLAIN, 32'h0000_00A5, 6'd8, 6'd0, 6'd0, 1'b1, 8'hA5, 16'd0, 32'd8},
		'{ACT_PLAIN, 32'hFFFF_FFFF, 6'd8, 6'd0, 6'd0, 1'b1, 8'hFF, 16'd1, 32'd16},
		'{ACT_PLAIN, 32'h0000_0000, 6'd0, 6'd63, 6'd63, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_PLAIN, 32'hFFFF_FFFF, 6'd32, 6'd0, 6'd0, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_PLAIN, 32'h1234_5678, 6'd63, 6'd0, 6'd0, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_PLAIN, 32'hFFFF_FFFF, 6'd33, 6'd0, 6'd0, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_PLAIN, 32'h0000_0005, 6'd3, 6'd0, 6'd0, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_ESCAPE, 32'h0000_0000, 6'd3, 6'd4, 6'd5, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_ESCAPE, 32'h0000_0007, 6'd3, 6'd5, 6'd2, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_ESCAPE, 32'h0000_0000, 6'd0, 6'd0, 6'd0, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_ESCAPE, 32'hFFFF_FFFF, 6'd32, 6'd32, 6'd32, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_ESCAPE, 32'hFFFF_FFFF, 6'd0, 6'd32, 6'd32, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_ESCAPE, 32'h0000_000A, 6'd2, 6'd2, 6'd4, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_ESCAPE, 32'hFFFF_FFFF, 6'd8, 6'd8, 6'd32, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_ESCAPE, 32'h8000_0000, 6'd31, 6'd63, 6'd40, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_ESCAPE, 32'h0000_0014, 6'd1, 6'd63, 6'd0, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_ESCAPE, 32'h0000_0064, 6'd4, 6'd4, 6'd0, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_PLAIN, 32'h0000_0000, 6'd1, 6'd0, 6'd0, 1'b0, 8'h00, 16'd0, 32'd0},
		'{ACT_PLAIN, 32'hFFFF_FFE3, 6'd5, 6'd33, 6'd48, 1'b0, 8'h00, 16'd0, 32'd0}
	};

	bit [evbp_pkg::BUF_W-1:0] ring_plan [NUM_PHASES] = '{
		17'd3, 17'd1, 17'd0, 17'h1FFFF, 17'd65535, 17'd5, 17'h10000
	};

	logic clk = 1'b0;
	logic arst_n;

	evbp_item_if item_in ();
	evbp_res_if res_out ();
	evbp_cfg_if cfg ();

	escaped_value_bit_packer_core #(
		.SLOT_INDEX_BITS(SLOT_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(item_in),
		.res_out(res_out),
		.cfg(cfg)
	);

	always #5 clk = ~clk;

	packed_byte_t expected_bytes [$];
	bit [7:0] pend_byte = 8'h00;
	bit [2:0] bit_pos = 3'd7;
	bit [evbp_pkg::SLOT_W-1:0] slot_idx = '0;
	bit [31:0] bits_written = '0;
	bit [evbp_pkg::BUF_W-1:0] ring_len = evbp_pkg::BUF_RESET;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	function automatic int unsigned eff_width(input bit [5:0] w);
		return (w > 6'd32) ? 32 : int'(w);
	endfunction

	function automatic bit [31:0] sat_limit(input int unsigned w);
		return (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
	endfunction

	function automatic void append_field(input bit [31:0] v, input int unsigned nbits);
		packed_byte_t pb;
		bit [31:0] nxt;
		for (int unsigned i = nbits; i > 0; i--) begin
			pend_byte[bit_pos] = v[i-1];
			bits_written = bits_written + 32'd1;
			if (bit_pos == 3'd0) begin
				pb.data = pend_byte;
				pb.slot = slot_idx;
				pb.total = bits_written;
				pb.last = 1'b0;
				expected_bytes.push_back(pb);
				nxt = 32'(slot_idx) + 32'd1;
				if (nxt >= 32'(ring_len) || nxt > ((32'd1 << SLOT_BITS) - 32'd1))
					nxt = '0;
				slot_idx = nxt[evbp_pkg::SLOT_W-1:0];
				pend_byte = 8'h00;
				bit_pos = 3'd7;
			end else begin
				bit_pos = bit_pos - 3'd1;
			end
		end
	endfunction

	function automatic void predict_item(input pack_req_t it);
		int unsigned n0;
		int unsigned wd [3];
		bit [31:0] rest;
		bit [31:0] lim;
		bit [31:0] e;
		packed_byte_t pb;
		n0 = expected_bytes.size();
		wd[0] = eff_width(it.w1);
		wd[1] = eff_width(it.w2);
		wd[2] = eff_width(it.w3);
		if (it.action == ACT_PLAIN) begin
			append_field(it.value, wd[0]);
		end else begin
			rest = it.value;
			for (int k = 0; k < 3; k++) begin
				lim = sat_limit(wd[k]);
				e = (rest < lim) ? rest : lim;
				append_field(e, wd[k]);
				if (e != lim)
					break;
				rest = rest - e;
			end
		end
		if (expected_bytes.size() > n0) begin
			pb = expected_bytes.pop_back();
			pb.last = 1'b1;
			expected_bytes.push_back(pb);
		end
	endfunction

	function automatic bit [5:0] rand_width();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 6'd0;
		else if (r < 70)
			return 6'($urandom_range(1, 8));
		else if (r < 90)
			return 6'($urandom_range(9, 32));
		else
			return 6'($urandom_range(33, 63));
	endfunction

	function automatic pack_req_t rand_item();
		pack_req_t it;
		bit [33:0] sum;
		bit [31:0] lim1;
		bit [31:0] lim2;
		it.action = ($urandom_range(0, 99) < 65) ? ACT_ESCAPE : ACT_PLAIN;
		it.w1 = rand_width();
		it.w2 = rand_width();
		it.w3 = rand_width();
		lim1 = sat_limit(eff_width(it.w1));
		lim2 = sat_limit(eff_width(it.w2));
		// steer escape values into each field
		case ($urandom_range(0, 3))
			0: begin
				sum = 34'($urandom);
			end
			1: begin
				sum = 34'($urandom_range(0, lim1));
			end
			2: begin
				sum = 34'(lim1) + 34'($urandom_range(0, lim2));
			end
			default: begin
				sum = 34'(lim1) + 34'(lim2) + 34'($urandom_range(0, 255));
			end
		endcase
		it.value = (sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
		return it;
	endfunction

	function automatic void check_field(input string name, input bit [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_item(input pack_req_t it, input bit typed, input packed_byte_t want);
		int unsigned n0;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			item_in.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		item_in.valid <= 1'b1;
		item_in.action <= it.action;
		item_in.value <= it.value;
		item_in.width_first <= it.w1;
		item_in.width_second <= it.w2;
		item_in.width_third <= it.w3;
		do @(posedge clk); while (item_in.ready !== 1'b1);
		n0 = expected_bytes.size();
		predict_item(it);
		if (typed) begin
			while (expected_bytes.size() > n0)
				void'(expected_bytes.pop_back());
			expected_bytes.push_back(want);
		end
	endtask

	task automatic write_ring_len(input bit [evbp_pkg::BUF_W-1:0] n);
		cfg.valid <= 1'b1;
		cfg.buffer_bytes <= n;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		ring_len = n;
	endtask

	task automatic drain_and_settle();
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		packed_byte_t pb;
		if (res_out.valid === 1'b1 && res_out.ready === 1'b1) begin
			if (expected_bytes.size() == 0) begin
				$error("out_byte: expected none, actual %0h", res_out.out_byte);
				mismatches++;
			end else begin
				pb = expected_bytes.pop_front();
				check_field("out_byte", 32'(pb.data), 32'(res_out.out_byte));
				check_field("byte_slot", 32'(pb.slot), 32'(res_out.byte_slot));
				check_field("total_bits", pb.total, res_out.total_bits);
				check_field("last", 32'(pb.last), 32'(res_out.last));
			end
		end
		res_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((item_in.valid === 1'b1 && item_in.ready === 1'b1)
			|| (res_out.valid === 1'b1 && res_out.ready === 1'b1)
			|| (cfg.valid === 1'b1 && cfg.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		pack_req_t it;
		packed_byte_t want;
		stim_row_t row;
		arst_n = 1'b0;
		item_in.valid = 1'b0;
		item_in.action = ACT_PLAIN;
		item_in.value = '0;
		item_in.width_first = '0;
		item_in.width_second = '0;
		item_in.width_third = '0;
		cfg.valid = 1'b0;
		cfg.buffer_bytes = evbp_pkg::BUF_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_ROWS; r++) begin
			row = directed_rows[r];
			it = '{row.action, row.value, row.w1, row.w2, row.w3};
			want = '{row.want_byte, row.want_slot, row.want_total, 1'b1};
			send_item(it, row.typed, want);
		end
		item_in.valid <= 1'b0;

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_and_settle();
			write_ring_len(ring_plan[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 58;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 58;
				end
				default: begin
					send_idle_pct = 23;
					recv_stall_pct = 23;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(rand_item(), 1'b0, '0);
			item_in.valid <= 1'b0;
		end

		drain_and_settle();
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
